>>> rtl/gdsc_pkg.sv
`timescale 1ns / 1ps

package gdsc_pkg;

   // Request codes carried in req_type
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_BUTTON = 2'd1;
   localparam logic [1:0] REQ_SENSOR = 2'd2;

   // Configuration register indexes
   localparam logic CSR_MOVE_TICKS  = 1'b0;
   localparam logic CSR_BLINK_TICKS = 1'b1;

   // Reset values
   localparam logic [15:0] MOVE_TICKS_RESET  = 16'd1000;
   localparam logic [15:0] BLINK_TICKS_RESET = 16'd100;
   localparam logic [15:0] TICK_COUNT_RESET  = 16'd1;

   // Sensor levels
   localparam logic SENSOR_PRESENT = 1'b0;
   localparam logic SENSOR_CLEAR   = 1'b1;

   typedef enum logic [1:0] {
      MODE_CLOSED  = 2'd0,
      MODE_OPENING = 2'd1,
      MODE_OPEN    = 2'd2,
      MODE_CLOSING = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       sensor_level;
   } req_word_type;

   typedef struct packed {
      logic [3:0] coil_pattern;
      logic       led_green;
      logic       led_blue;
      logic       led_red;
      logic [1:0] door_mode;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] move_ticks;
      logic [15:0] blink_ticks;
   } cfg_type;

   // Full-step drive pattern A,A',B,B' for each phase
   function automatic logic [3:0] coil_of(input logic [1:0] phase);
      logic [3:0] pattern;
      case (phase)
         2'd0:    pattern = 4'b1100;
         2'd1:    pattern = 4'b0110;
         2'd2:    pattern = 4'b0011;
         2'd3:    pattern = 4'b1001;
         default: pattern = 4'b1100;
      endcase
      return pattern;
   endfunction

endpackage

>>> rtl/gdsc_core.sv
`timescale 1ns / 1ps

module gdsc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  gdsc_pkg::req_word_type item,
   input  gdsc_pkg::cfg_type     cfg,
   output gdsc_pkg::rsp_word_type result
);

   gdsc_pkg::mode_type mode_ff, mode_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] blink_ff, blink_in;
   logic        red_ff, red_in;

   logic        moving;
   logic        opening;
   logic        start;
   gdsc_pkg::mode_type target;
   logic [15:0] tick_inc;
   logic [15:0] blink_inc;

   assign opening   = (mode_ff == gdsc_pkg::MODE_OPENING);
   assign moving    = opening || (mode_ff == gdsc_pkg::MODE_CLOSING);
   assign tick_inc  = tick_ff + 16'd1;
   assign blink_inc = blink_ff + 16'd1;

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      blink_in = blink_ff;
      red_in   = red_ff;
      start    = 1'b0;
      target   = mode_ff;

      case (item.req_type)
         gdsc_pkg::REQ_TICK: begin
            if (moving) begin
               phase_in = opening ? (phase_ff + 2'd1) : (phase_ff - 2'd1);
               tick_in  = tick_inc;
               if (cfg.blink_ticks != 16'd0) begin
                  if (blink_inc >= cfg.blink_ticks) begin
                     blink_in = 16'd0;
                     red_in   = ~red_ff;
                  end else begin
                     blink_in = blink_inc;
                  end
               end
               if (tick_inc >= cfg.move_ticks) begin
                  mode_in = opening ? gdsc_pkg::MODE_OPEN : gdsc_pkg::MODE_CLOSED;
                  tick_in = gdsc_pkg::TICK_COUNT_RESET;
                  red_in  = 1'b0;
               end
            end
         end
         gdsc_pkg::REQ_BUTTON: begin
            if (mode_ff == gdsc_pkg::MODE_CLOSED) begin
               start  = 1'b1;
               target = gdsc_pkg::MODE_OPENING;
            end else if (mode_ff == gdsc_pkg::MODE_OPEN) begin
               start  = 1'b1;
               target = gdsc_pkg::MODE_CLOSING;
            end
         end
         gdsc_pkg::REQ_SENSOR: begin
            if (item.sensor_level == gdsc_pkg::SENSOR_PRESENT &&
                mode_ff == gdsc_pkg::MODE_CLOSED) begin
               start  = 1'b1;
               target = gdsc_pkg::MODE_OPENING;
            end else if (item.sensor_level == gdsc_pkg::SENSOR_CLEAR &&
                         mode_ff == gdsc_pkg::MODE_OPEN) begin
               start  = 1'b1;
               target = gdsc_pkg::MODE_CLOSING;
            end
         end
         default: begin
         end
      endcase

      if (start) begin
         mode_in  = target;
         tick_in  = gdsc_pkg::TICK_COUNT_RESET;
         blink_in = (cfg.blink_ticks > 16'd1) ? 16'd1 : 16'd0;
         red_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= gdsc_pkg::MODE_CLOSED;
         phase_ff <= 2'd0;
         tick_ff  <= gdsc_pkg::TICK_COUNT_RESET;
         blink_ff <= 16'd0;
         red_ff   <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         blink_ff <= blink_in;
         red_ff   <= red_in;
      end
   end

   // Result shows the state after the word
   always_comb begin
      result.coil_pattern = gdsc_pkg::coil_of(phase_in);
      result.led_green    = (mode_in == gdsc_pkg::MODE_CLOSED);
      result.led_blue     = (mode_in == gdsc_pkg::MODE_OPEN);
      result.led_red      = red_in;
      result.door_mode    = mode_in;
   end

endmodule

>>> rtl/garage_door_stepper_controller.sv
`timescale 1ns / 1ps

// Garage door controller for a two-phase full-step stepper motor. Each request
// word is a timer tick, a button press or a sensor edge; each one yields exactly
// one response word showing the coil drive pattern, the LEDs and the door mode
// after that word. A word waits in the input register while the door state
// update works on it, and its response is captured in the response register
// when the word advances, that is once the response register is free or
// drains. One word is accepted every cycle as long as the response side keeps
// taking words; a stalled response holds the input register, and the input
// stalls once both are full. The single state update path sets that rate.
// Registers move_ticks (index 0) and blink_ticks (index 1) are written through
// the csr_ port and should only change while no word is in flight.
module garage_door_stepper_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gdsc_pkg::req_word_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gdsc_pkg::rsp_word_type  rsp_data,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [15:0]            csr_wr_data
);

   // Input register
   logic                  in_valid_ff, in_valid_in;
   gdsc_pkg::req_word_type in_data_ff;

   // Response register
   logic                  out_valid_ff, out_valid_in;
   gdsc_pkg::rsp_word_type out_data_ff;

   // Configuration registers
   gdsc_pkg::cfg_type     cfg_ff, cfg_in;

   gdsc_pkg::rsp_word_type result;
   logic                  advance;

   // Advance the held word whenever the response register is free or drains now
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            gdsc_pkg::CSR_MOVE_TICKS:  cfg_in.move_ticks  = csr_wr_data;
            gdsc_pkg::CSR_BLINK_TICKS: cfg_in.blink_ticks = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         cfg_ff.move_ticks  <= gdsc_pkg::MOVE_TICKS_RESET;
         cfg_ff.blink_ticks <= gdsc_pkg::BLINK_TICKS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   gdsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> rtl/gdsc_checker.sv
`timescale 1ns / 1ps

module gdsc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input gdsc_pkg::rsp_word_type  rsp_data
);

   // A stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word dropped or changed while stalled");

   // Green and blue LEDs follow the resting modes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.led_green == (rsp_data.door_mode == gdsc_pkg::MODE_CLOSED)) &&
         (rsp_data.led_blue  == (rsp_data.door_mode == gdsc_pkg::MODE_OPEN)))
      else $error("rest LEDs disagree with door mode");

   // Red LED is dark at rest
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.door_mode == gdsc_pkg::MODE_CLOSED ||
                    rsp_data.door_mode == gdsc_pkg::MODE_OPEN)
      |-> !rsp_data.led_red)
      else $error("red LED lit while door rests");

   // Coil drive is always one of the four full-step patterns
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.coil_pattern == 4'b1100 || rsp_data.coil_pattern == 4'b0110 ||
          rsp_data.coil_pattern == 4'b0011 || rsp_data.coil_pattern == 4'b1001))
      else $error("illegal coil pattern");

endmodule

bind garage_door_stepper_controller gdsc_checker u_gdsc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> verif/garage_door_stepper_controller_tb.sv
`timescale 1ns / 1ps

// Tracks the door state on the accepted request words and holds the status
// words that the block still owes, oldest first.
class door_status_board;
   logic [15:0]            move_ticks;
   logic [15:0]            blink_ticks;
   gdsc_pkg::mode_type     mode;
   logic [1:0]             coil_phase;
   logic [15:0]            tick_count;
   logic [15:0]            blink_count;
   logic                   red_on;
   gdsc_pkg::rsp_word_type status_queue[$];
   int                     errors;

   function new();
      move_ticks  = gdsc_pkg::MOVE_TICKS_RESET;
      blink_ticks = gdsc_pkg::BLINK_TICKS_RESET;
      mode        = gdsc_pkg::MODE_CLOSED;
      coil_phase  = 2'd0;
      tick_count  = gdsc_pkg::TICK_COUNT_RESET;
      blink_count = 16'd0;
      red_on      = 1'b0;
      errors      = 0;
   endfunction

   function void set_register(logic index, logic [15:0] value);
      if (index == gdsc_pkg::CSR_MOVE_TICKS) begin
         move_ticks = value;
      end else begin
         blink_ticks = value;
      end
   endfunction

   function logic [3:0] coil_drive(logic [1:0] phase);
      logic [3:0] pattern;
      case (phase)
         2'd0:    pattern = 4'b1100;
         2'd1:    pattern = 4'b0110;
         2'd2:    pattern = 4'b0011;
         default: pattern = 4'b1001;
      endcase
      return pattern;
   endfunction

   function void start_move(gdsc_pkg::mode_type target);
      mode        = target;
      tick_count  = 16'd1;
      blink_count = (blink_ticks > 16'd1) ? 16'd1 : 16'd0;
      red_on      = 1'b0;
   endfunction

   // Advance one full step: phase up while opening, phase down while closing.
   function void step_motor();
      logic opening;
      opening    = (mode == gdsc_pkg::MODE_OPENING);
      coil_phase = opening ? coil_phase + 2'd1 : coil_phase - 2'd1;
      tick_count = tick_count + 16'd1;
      if (blink_ticks != 16'd0) begin
         blink_count = blink_count + 16'd1;
         if (blink_count >= blink_ticks) begin
            blink_count = 16'd0;
            red_on      = ~red_on;
         end
      end
      if (tick_count >= move_ticks) begin
         if (opening) begin
            mode = gdsc_pkg::MODE_OPEN;
         end else begin
            mode = gdsc_pkg::MODE_CLOSED;
         end
         tick_count = 16'd1;
         red_on     = 1'b0;
      end
   endfunction

   function void note_request(gdsc_pkg::req_word_type word);
      gdsc_pkg::rsp_word_type status;
      case (word.req_type)
         gdsc_pkg::REQ_TICK: begin
            if (mode == gdsc_pkg::MODE_OPENING || mode == gdsc_pkg::MODE_CLOSING) begin
               step_motor();
            end
         end
         gdsc_pkg::REQ_BUTTON: begin
            if (mode == gdsc_pkg::MODE_CLOSED) begin
               start_move(gdsc_pkg::MODE_OPENING);
            end else if (mode == gdsc_pkg::MODE_OPEN) begin
               start_move(gdsc_pkg::MODE_CLOSING);
            end
         end
         gdsc_pkg::REQ_SENSOR: begin
            if (word.sensor_level == gdsc_pkg::SENSOR_PRESENT &&
                mode == gdsc_pkg::MODE_CLOSED) begin
               start_move(gdsc_pkg::MODE_OPENING);
            end else if (word.sensor_level == gdsc_pkg::SENSOR_CLEAR &&
                         mode == gdsc_pkg::MODE_OPEN) begin
               start_move(gdsc_pkg::MODE_CLOSING);
            end
         end
         default: ;
      endcase
      status.coil_pattern = coil_drive(coil_phase);
      status.led_green    = (mode == gdsc_pkg::MODE_CLOSED);
      status.led_blue     = (mode == gdsc_pkg::MODE_OPEN);
      status.led_red      = red_on;
      status.door_mode    = mode;
      status_queue.push_back(status);
   endfunction

   function void check_status(gdsc_pkg::rsp_word_type actual);
      gdsc_pkg::rsp_word_type wanted;
      if (status_queue.size() == 0) begin
         $error("status word %h arrived with none outstanding", actual);
         errors++;
         return;
      end
      wanted = status_queue.pop_front();
      if (actual.coil_pattern !== wanted.coil_pattern) begin
         $error("coil_pattern: expected %b, actual %b", wanted.coil_pattern,
                actual.coil_pattern);
         errors++;
      end
      if (actual.led_green !== wanted.led_green) begin
         $error("led_green: expected %b, actual %b", wanted.led_green, actual.led_green);
         errors++;
      end
      if (actual.led_blue !== wanted.led_blue) begin
         $error("led_blue: expected %b, actual %b", wanted.led_blue, actual.led_blue);
         errors++;
      end
      if (actual.led_red !== wanted.led_red) begin
         $error("led_red: expected %b, actual %b", wanted.led_red, actual.led_red);
         errors++;
      end
      if (actual.door_mode !== wanted.door_mode) begin
         $error("door_mode: expected %0d, actual %0d", wanted.door_mode,
                actual.door_mode);
         errors++;
      end
   endfunction

   function int outstanding();
      return status_queue.size();
   endfunction
endclass

module garage_door_stepper_controller_tb;

   // Code left unused by the block; it must change nothing.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // Generous bound on the whole run, far above the slowest legal run.
   localparam int CYCLE_LIMIT = 400000;
   // Long receiver hold-off, enough to back the block up into its input.
   localparam int HOLD_CYCLES = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   gdsc_pkg::req_word_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   gdsc_pkg::rsp_word_type rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic                   csr_index = gdsc_pkg::CSR_MOVE_TICKS;
   logic [15:0]            csr_wr_data = '0;

   door_status_board board = new();

   int cycle_count    = 0;
   int rx_idle_pct    = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;

   garage_door_stepper_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Sample both handshakes at the edge, before any driver update lands.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_status(rsp_data);
      end
   end

   // Receiver: stall at the current idle rate; on request, hold off for a long
   // stretch counted here so the block fills and stalls its input.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Offer one request word, maybe after idle cycles, and hold it until taken.
   // Call at a rising edge; return at the edge that accepts the word.
   task automatic send_event(logic [1:0] kind, logic level, int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{req_type: kind, sensor_level: level};
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait for every owed status word, plus the pipeline depth.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Write both registers back to back while the block is idle.
   task automatic write_config(logic [15:0] move_value, logic [15:0] blink_value);
      csr_wr_en   <= 1'b1;
      csr_index   <= gdsc_pkg::CSR_MOVE_TICKS;
      csr_wr_data <= move_value;
      @(posedge clock);
      board.set_register(gdsc_pkg::CSR_MOVE_TICKS, move_value);
      csr_index   <= gdsc_pkg::CSR_BLINK_TICKS;
      csr_wr_data <= blink_value;
      @(posedge clock);
      board.set_register(gdsc_pkg::CSR_BLINK_TICKS, blink_value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly ticks, so moves run to the end, with presses, sensor edges of
   // either level and the odd unused code mixed in.
   task automatic run_random(int count, int tx_idle);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_event(gdsc_pkg::REQ_TICK, 1'($urandom_range(0, 1)), tx_idle);
         end else if (pick < 82) begin
            send_event(gdsc_pkg::REQ_BUTTON, 1'($urandom_range(0, 1)), tx_idle);
         end else if (pick < 96) begin
            send_event(gdsc_pkg::REQ_SENSOR, 1'($urandom_range(0, 1)), tx_idle);
         end else begin
            send_event(REQ_UNUSED, 1'($urandom_range(0, 1)), tx_idle);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: tick at rest shows 1100 and green, unused code and a
      // clear sensor edge on a closed door change nothing.
      send_event(gdsc_pkg::REQ_TICK, 1'b0, 0);
      send_event(REQ_UNUSED, 1'b1, 0);
      send_event(gdsc_pkg::REQ_SENSOR, gdsc_pkg::SENSOR_CLEAR, 0);
      drain();

      // Short moves: 3 steps each, red toggles every second tick.
      write_config(16'd4, 16'd2);
      send_event(gdsc_pkg::REQ_SENSOR, gdsc_pkg::SENSOR_PRESENT, 0); // open on present
      send_event(gdsc_pkg::REQ_BUTTON, 1'b0, 0);             // ignored while moving
      send_event(gdsc_pkg::REQ_SENSOR, gdsc_pkg::SENSOR_CLEAR, 0);
      send_event(REQ_UNUSED, 1'b0, 0);
      repeat (3) send_event(gdsc_pkg::REQ_TICK, 1'b0, 0);    // last tick rests open
      send_event(gdsc_pkg::REQ_TICK, 1'b1, 0);               // tick at rest
      send_event(gdsc_pkg::REQ_SENSOR, gdsc_pkg::SENSOR_PRESENT, 0); // no close
      send_event(gdsc_pkg::REQ_BUTTON, 1'b1, 0);             // button closes
      repeat (3) send_event(gdsc_pkg::REQ_TICK, 1'b0, 0);
      send_event(gdsc_pkg::REQ_SENSOR, gdsc_pkg::SENSOR_CLEAR, 0);   // no open
      send_event(gdsc_pkg::REQ_BUTTON, 1'b0, 0);             // button opens
      repeat (3) send_event(gdsc_pkg::REQ_TICK, 1'b0, 0);
      send_event(gdsc_pkg::REQ_SENSOR, gdsc_pkg::SENSOR_CLEAR, 0);   // clear closes
      repeat (3) send_event(gdsc_pkg::REQ_TICK, 1'b0, 0);
      drain();

      // Sender idles lightly, receiver heavily.
      rx_idle_pct = 51;
      write_config(16'd8, 16'd3);
      run_random(300, 17);
      drain();
      write_config(16'd2, 16'd1);
      run_random(250, 17);
      drain();

      // Swap the idle rates; the widest settings leave a move unfinished.
      rx_idle_pct = 17;
      write_config(16'd30, 16'd7);
      run_random(250, 51);
      drain();
      write_config(16'hFFFF, 16'hFFFF);
      run_random(100, 51);
      drain();

      // No idling; zero settings end any move on the next tick and freeze red.
      // Hold the receiver off while the sender keeps offering words.
      rx_idle_pct = 0;
      write_config(16'd0, 16'd0);
      hold_requests++;
      run_random(250, 0);
      drain();
      write_config(16'd12, 16'd5);
      run_random(250, 0);
      drain();

      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
